// File: design/vdt_pkg.sv
// vdt_pkg: shared types and constants for the vertex dedup table.
// Used by vdt_key_ram, vdt_scan_ctrl and vertex_dedup_table; no dependencies.

package vdt_pkg;

  // Table geometry
  localparam int unsigned CAPACITY  = 4096;
  localparam int unsigned ADDR_W    = $clog2(CAPACITY);
  localparam int unsigned COUNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned KEY_W     = 5 * COORD_W;
  localparam int unsigned OUT_IDX_W = 12;
  localparam int unsigned OUT_DATA_W = 16;

  // Function codes carried in the input tuser
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;

  // One lookup result handed from the sequencer to the output register
  typedef struct packed {
    logic [OUT_IDX_W-1:0] idx;
    logic                 added;
    logic                 full;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

// File: design/vdt_key_ram.sv
// vdt_key_ram: key store, one write port and one registered read port.
// Depends on vdt_pkg for widths and depth.

module vdt_key_ram (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  vdt_pkg::addr_t wr_addr_i,
  input  vdt_pkg::key_t  wr_data_i,
  input  vdt_pkg::addr_t rd_addr_i,
  output vdt_pkg::key_t  rd_data_o
);

  vdt_pkg::key_t mem [vdt_pkg::CAPACITY];
  vdt_pkg::key_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data arrives in the cycle after the address
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/vdt_scan_ctrl.sv
// vdt_scan_ctrl: sequencer that walks the filled entries with one shared
// 160-bit comparator, appends on a miss and clears the fill count.
// Depends on vdt_pkg and instantiates vdt_key_ram.

module vdt_scan_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_func_i,
  input  vdt_pkg::key_t     in_key_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output vdt_pkg::result_t  res_o,
  output vdt_pkg::count_t   count_o
);

  vdt_pkg::state_e  state_q, state_d;
  vdt_pkg::key_t    key_q, key_d;
  vdt_pkg::count_t  cnt_q, cnt_d;
  vdt_pkg::addr_t   ptr_q, ptr_d;
  vdt_pkg::result_t res_q, res_d;

  logic           wr_en;
  vdt_pkg::addr_t wr_addr;
  vdt_pkg::key_t  wr_data;
  vdt_pkg::addr_t rd_addr;
  vdt_pkg::key_t  rd_data;
  logic           hit;
  logic           last;

  vdt_key_ram u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Shared comparator and end-of-table check
  assign hit  = (rd_data == key_q);
  assign last = ((vdt_pkg::COUNT_W'(ptr_q) + vdt_pkg::COUNT_W'(1)) == cnt_q);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vdt_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    ptr_q <= ptr_d;
    res_q <= res_d;
  end

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    res_d       = res_q;
    wr_en       = 1'b0;
    wr_addr     = cnt_q[vdt_pkg::ADDR_W-1:0];
    wr_data     = key_q;
    rd_addr     = ptr_q + vdt_pkg::ADDR_W'(1);
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      vdt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        rd_addr    = '0;
        if (in_valid_i) begin
          key_d = in_key_i;
          if (in_func_i == vdt_pkg::FUNC_CLEAR) begin
            cnt_d   = '0;
            res_d   = '0;
            state_d = vdt_pkg::ST_DONE;
          end else if (cnt_q == '0) begin
            // empty table: append at entry 0 without scanning
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = in_key_i;
            cnt_d     = vdt_pkg::COUNT_W'(1);
            res_d     = '0;
            res_d.added = 1'b1;
            state_d   = vdt_pkg::ST_DONE;
          end else begin
            ptr_d   = '0;
            state_d = vdt_pkg::ST_SCAN;
          end
        end
      end

      vdt_pkg::ST_SCAN: begin
        // rd_data holds entry ptr_q; the read for ptr_q+1 goes out now
        if (hit) begin
          res_d     = '0;
          res_d.idx = vdt_pkg::OUT_IDX_W'(ptr_q);
          state_d   = vdt_pkg::ST_DONE;
        end else if (last) begin
          res_d = '0;
          if (cnt_q == vdt_pkg::COUNT_W'(vdt_pkg::CAPACITY)) begin
            res_d.full = 1'b1;
          end else begin
            wr_en       = 1'b1;
            cnt_d       = cnt_q + vdt_pkg::COUNT_W'(1);
            res_d.idx   = vdt_pkg::OUT_IDX_W'(cnt_q);
            res_d.added = 1'b1;
          end
          state_d = vdt_pkg::ST_DONE;
        end else begin
          ptr_d = ptr_q + vdt_pkg::ADDR_W'(1);
        end
      end

      vdt_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = vdt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = vdt_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_o   = res_q;
  assign count_o = cnt_q;

endmodule

// File: design/vertex_dedup_table.sv
// vertex_dedup_table: top level, stream ports and the output register.
// Depends on vdt_pkg and instantiates vdt_scan_ctrl.
//
// Usage:
//   Input beats arrive on s_axis; tuser selects insert (0) or clear (1),
//   tdata carries the five Q16.16 key words. Each beat yields exactly one
//   output beat on m_axis: tdata holds the vertex index, tuser the
//   was_added and table_full flags.
//   An insert compares one stored entry per cycle through the key RAM's
//   registered read port and a single 160-bit comparator. A hit ends the
//   scan at the matching index i; a miss on a table of n entries scans all
//   n and then appends the key at index n, or reports table_full when the
//   table holds 4096 entries. An empty table appends at entry 0 without
//   scanning, and a clear goes straight to its result.
//   s_axis_tready_o is high only while the sequencer is idle; one item is
//   worked on at a time.
//   A finished result sits in the output register; the sequencer takes the
//   next item while it waits, and holds its own result if the receiver
//   still stalls when the next one is done.
//   Reset empties the table (fill count zero); the key RAM is not cleared.

module vertex_dedup_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [127:96] tex_u, [159:128] tex_v
  input  logic [159:0] s_axis_tdata_i,
  // [0] func
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [11:0] vertex_index, [15:12] zero
  output logic [15:0]  m_axis_tdata_o,
  // [0] was_added, [1] table_full
  output logic [1:0]   m_axis_tuser_o
);

  logic             res_valid;
  logic             res_ready;
  vdt_pkg::result_t res;
  vdt_pkg::count_t  count;

  logic             m_valid_q;
  vdt_pkg::result_t m_res_q;

  vdt_scan_ctrl u_scan_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_func_i   (s_axis_tuser_i),
    .in_key_i    (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .count_o     (count)
  );

  // Output register takes a result when empty or being drained
  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = vdt_pkg::OUT_DATA_W'(m_res_q.idx);
  assign m_axis_tuser_o  = {m_res_q.full, m_res_q.added};

`ifndef SYNTH
  // Fill count stays within the table
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= vdt_pkg::COUNT_W'(vdt_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  // An appended index is the last filled entry
  a_added_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.added |->
      vdt_pkg::OUT_IDX_W'(count - vdt_pkg::COUNT_W'(1)) == res.idx)
    else $error("appended index does not match fill count");

  // A full report only with a full table, and never together with added
  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.full |->
      count == vdt_pkg::COUNT_W'(vdt_pkg::CAPACITY) && !res.added)
    else $error("full flag with free entries");

  // No new input while a result is held in the sequencer
  a_busy_when_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !s_axis_tready_o)
    else $error("input accepted with a result pending");
`endif

endmodule
